// ===== hw/rtl/inverse_color_transform_finalize_unit_assert.svh =====
// Assertion macros for the inverse color transform finalize unit checker.
// Expects clk and rst to be visible in the scope that uses the macros.
`ifndef INVERSE_COLOR_TRANSFORM_FINALIZE_UNIT_ASSERT_SVH
`define INVERSE_COLOR_TRANSFORM_FINALIZE_UNIT_ASSERT_SVH

// A stalled transaction keeps its payload on the next cycle.
`define ICF_ASSERT_HOLD(lbl, vld, rdy, sig) \
  lbl: assert property (@(posedge clk) disable iff (rst) ((vld) && !(rdy)) |=> $stable(sig)) \
    else $error("stalled transaction changed its payload");

// Same-cycle implication.
`define ICF_ASSERT_IMPLY(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("implication check failed");

`endif

// ===== hw/rtl/icf_pkg.sv =====
// Shared types and constants for the inverse color transform finalize unit.
// No dependencies; used by every module of the block.
package icf_pkg;

  // Default elaboration values
  localparam int FRAC_BITS_DEF   = 4;
  localparam int COEF_BITS_DEF   = 16;
  localparam int SAMPLE_BITS_DEF = 24;

  // Fixed field widths
  localparam int OUT_W      = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int SHIFT_W    = 5;
  localparam int ROUND_W    = 15;
  localparam int DC_W       = 16;
  localparam int LANES      = 3;

  // Register indexes on the configuration channel
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE  = 3'd0,
    REG_SHIFT = 3'd1,
    REG_ROUND = 3'd2,
    REG_DC    = 3'd3,
    REG_MIN   = 3'd4,
    REG_MAX   = 3'd5
  } reg_idx_t;

  typedef enum logic {
    MODE_RCT = 1'b0,
    MODE_ICT = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t                      mode;
    logic signed [SHIFT_W-1:0]  shift;
    logic        [ROUND_W-1:0]  round;
    logic        [DC_W-1:0]     dc;
    logic signed [OUT_W-1:0]    min_val;
    logic signed [OUT_W-1:0]    max_val;
  } cfg_t;

  // Reset values
  localparam logic signed [SHIFT_W-1:0] SHIFT_RESET = '0;
  localparam logic        [ROUND_W-1:0] ROUND_RESET = '0;
  localparam logic        [DC_W-1:0]    DC_RESET    = '0;
  localparam logic signed [OUT_W-1:0]   MIN_RESET   = 17'sd0;
  localparam logic signed [OUT_W-1:0]   MAX_RESET   = 17'sd255;

endpackage

// ===== hw/rtl/icf_regs.sv =====
// Configuration register file of the inverse color transform finalize unit.
// Depends on icf_pkg.
module icf_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [icf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [icf_pkg::CFG_DATA_W-1:0]   cfg_data,
  output icf_pkg::cfg_t                    cfg
);

  icf_pkg::cfg_t regs;

  // Writes are always accepted
  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.mode    <= icf_pkg::MODE_RCT;
      regs.shift   <= icf_pkg::SHIFT_RESET;
      regs.round   <= icf_pkg::ROUND_RESET;
      regs.dc      <= icf_pkg::DC_RESET;
      regs.min_val <= icf_pkg::MIN_RESET;
      regs.max_val <= icf_pkg::MAX_RESET;
    end else if (cfg_valid) begin
      case (icf_pkg::reg_idx_t'(cfg_index))
        icf_pkg::REG_MODE:  regs.mode    <= icf_pkg::mode_t'(cfg_data[0]);
        icf_pkg::REG_SHIFT: regs.shift   <= cfg_data[icf_pkg::SHIFT_W-1:0];
        icf_pkg::REG_ROUND: regs.round   <= cfg_data[icf_pkg::ROUND_W-1:0];
        icf_pkg::REG_DC:    regs.dc      <= cfg_data[icf_pkg::DC_W-1:0];
        icf_pkg::REG_MIN:   regs.min_val <= cfg_data[icf_pkg::OUT_W-1:0];
        icf_pkg::REG_MAX:   regs.max_val <= cfg_data[icf_pkg::OUT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/icf_xform.sv =====
// Color transform pipeline, stages 1 to 3: inverse RCT and fixed-point inverse ICT.
// Depends on icf_pkg; feeds icf_final.
module icf_xform #(
  parameter int FRAC_BITS   = icf_pkg::FRAC_BITS_DEF,
  parameter int COEF_BITS   = icf_pkg::COEF_BITS_DEF,
  parameter int SAMPLE_BITS = icf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                               clk,
  input  logic                                               rst,
  input  icf_pkg::cfg_t                                      cfg,
  input  logic                                               in_valid,
  output logic                                               in_ready,
  input  logic signed [SAMPLE_BITS-1:0]                      y_in,
  input  logic signed [SAMPLE_BITS-1:0]                      cb_in,
  input  logic signed [SAMPLE_BITS-1:0]                      cr_in,
  input  logic                                               in_last,
  output logic                                               out_valid,
  input  logic                                               out_ready,
  output logic [icf_pkg::LANES-1:0][SAMPLE_BITS+3:0]         out_x,
  output logic                                               out_last
);

  localparam int KW  = COEF_BITS + 2;           // coefficient width, signed
  localparam int PRW = SAMPLE_BITS + KW;        // product width
  localparam int PW  = SAMPLE_BITS + COEF_BITS + 3; // ICT sum width
  localparam int RW  = SAMPLE_BITS + 1;         // rounded integer width
  localparam int GW  = SAMPLE_BITS + 3;         // RCT green width
  localparam int XW  = SAMPLE_BITS + 4;         // stage 3 result width
  localparam int TS  = FRAC_BITS + COEF_BITS;   // truncating shift

  localparam longint ONE    = longint'(1) << COEF_BITS;
  localparam longint KCRR_L = (1402 * ONE + 500) / 1000;
  localparam longint KCRG_L = (714136 * ONE + 500000) / 1000000;
  localparam longint KCBG_L = (344136 * ONE + 500000) / 1000000;
  localparam longint KCBB_L = (1772 * ONE + 500) / 1000;

  localparam logic signed [KW-1:0] K_CR_R = KW'(KCRR_L);
  localparam logic signed [KW-1:0] K_CR_G = KW'(KCRG_L);
  localparam logic signed [KW-1:0] K_CB_G = KW'(KCBG_L);
  localparam logic signed [KW-1:0] K_CB_B = KW'(KCBB_L);

  localparam logic signed [RW-1:0] HALF       = RW'((longint'(1) << FRAC_BITS) >> 1);
  localparam logic signed [PW-1:0] TRUNC_BIAS = PW'((longint'(1) << TS) - 1);
  localparam logic signed [PW-1:0] ZERO_PW    = '0;

  // Stage valids and per-stage ready
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  assign rdy3      = !v3 || out_ready;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // ---------------- Stage 1: coefficient products, input rounding
  logic signed [PRW-1:0] p_crr_n, p_crg_n, p_cbg_n, p_cbb_n;
  logic signed [RW-1:0]  iy_n, icb_n, icr_n;

  assign p_crr_n = cr_in * K_CR_R;
  assign p_crg_n = cr_in * K_CR_G;
  assign p_cbg_n = cb_in * K_CB_G;
  assign p_cbb_n = cb_in * K_CB_B;

  // round to nearest, ties up
  assign iy_n  = (RW'(y_in)  + HALF) >>> FRAC_BITS;
  assign icb_n = (RW'(cb_in) + HALF) >>> FRAC_BITS;
  assign icr_n = (RW'(cr_in) + HALF) >>> FRAC_BITS;

  logic signed [PRW-1:0]         p_crr1, p_crg1, p_cbg1, p_cbb1;
  logic signed [SAMPLE_BITS-1:0] y1;
  logic signed [RW-1:0]          iy1, icb1, icr1;
  logic                          last1;

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      p_crr1 <= p_crr_n;
      p_crg1 <= p_crg_n;
      p_cbg1 <= p_cbg_n;
      p_cbb1 <= p_cbb_n;
      y1     <= y_in;
      iy1    <= iy_n;
      icb1   <= icb_n;
      icr1   <= icr_n;
      last1  <= in_last;
    end
  end

  // ---------------- Stage 2: ICT sums, RCT green
  logic signed [PW-1:0] ys;
  logic signed [PW-1:0] f_n [icf_pkg::LANES];
  logic signed [GW-1:0] cbcr_sum;
  logic signed [GW-1:0] g_n;

  assign ys     = PW'(y1) <<< COEF_BITS;
  assign f_n[0] = ys + PW'(p_crr1);
  assign f_n[1] = ys - PW'(p_crg1) - PW'(p_cbg1);
  assign f_n[2] = ys + PW'(p_cbb1);

  assign cbcr_sum = GW'(icb1) + GW'(icr1);
  assign g_n      = GW'(iy1) - (cbcr_sum >>> 2);

  logic signed [PW-1:0] f2 [icf_pkg::LANES];
  logic signed [GW-1:0] g2;
  logic signed [RW-1:0] icb2, icr2;
  logic                 last2;

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      f2    <= f_n;
      g2    <= g_n;
      icb2  <= icb1;
      icr2  <= icr1;
      last2 <= last1;
    end
  end

  // ---------------- Stage 3: truncate toward zero, RCT red/blue, mode select
  logic signed [PW-1:0] f_bias [icf_pkg::LANES];
  logic signed [PW-1:0] f_int  [icf_pkg::LANES];
  logic signed [XW-1:0] rct    [icf_pkg::LANES];
  logic [icf_pkg::LANES-1:0][XW-1:0] x_n;

  assign rct[0] = XW'(icr2) + XW'(g2);
  assign rct[1] = XW'(g2);
  assign rct[2] = XW'(icb2) + XW'(g2);

  for (genvar i = 0; i < icf_pkg::LANES; i++) begin : g_lane
    assign f_bias[i] = f2[i] + (f2[i][PW-1] ? TRUNC_BIAS : ZERO_PW);
    assign f_int[i]  = f_bias[i] >>> TS;
    assign x_n[i]    = (cfg.mode == icf_pkg::MODE_ICT) ? XW'(f_int[i]) : rct[i];
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      out_x    <= x_n;
      out_last <= last2;
    end
  end

endmodule

// ===== hw/rtl/icf_final.sv =====
// Finalize pipeline, stages 4 and 5: ICT shift, DC offset and clamp, three lanes.
// Depends on icf_pkg; its stage 5 register is the unit's output register.
module icf_final #(
  parameter int SAMPLE_BITS = icf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                               clk,
  input  logic                                               rst,
  input  icf_pkg::cfg_t                                      cfg,
  input  logic                                               in_valid,
  output logic                                               in_ready,
  input  logic [icf_pkg::LANES-1:0][SAMPLE_BITS+3:0]         in_x,
  input  logic                                               in_last,
  output logic                                               out_valid,
  input  logic                                               out_ready,
  output logic [icf_pkg::LANES-1:0][icf_pkg::OUT_W-1:0]      out_data,
  output logic                                               out_last
);

  localparam int XW = SAMPLE_BITS + 4;
  localparam int YW = XW + 17;    // room for a left shift by up to 16
  localparam int ZW = YW + 1;

  logic v4, v5;
  logic rdy4, rdy5;

  assign rdy5      = !v5 || out_ready;
  assign rdy4      = !v4 || rdy5;
  assign in_ready  = rdy4;
  assign out_valid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy4) v4 <= in_valid;
      if (rdy5) v5 <= v4;
    end
  end

  // ---------------- Stage 4: shift (ICT only)
  logic signed [YW-1:0] rnd_e;
  logic [4:0]           shl_amt;
  logic                 do_shr, do_shl;

  assign rnd_e   = YW'(cfg.round);
  assign shl_amt = 5'(-cfg.shift);
  assign do_shr  = (cfg.mode == icf_pkg::MODE_ICT) && !cfg.shift[4] && (cfg.shift != '0);
  assign do_shl  = (cfg.mode == icf_pkg::MODE_ICT) && cfg.shift[4];

  logic signed [YW-1:0] xe    [icf_pkg::LANES];
  logic signed [YW-1:0] rsum  [icf_pkg::LANES];
  logic signed [YW-1:0] sh_n  [icf_pkg::LANES];
  logic signed [YW-1:0] sh4   [icf_pkg::LANES];
  logic                 last4;

  for (genvar i = 0; i < icf_pkg::LANES; i++) begin : g_shift
    assign xe[i]   = YW'($signed(in_x[i]));
    assign rsum[i] = xe[i] + rnd_e;
    always_comb begin
      if (do_shr) begin
        sh_n[i] = rsum[i] >>> cfg.shift[3:0];
      end else if (do_shl) begin
        sh_n[i] = xe[i] <<< shl_amt;
      end else begin
        sh_n[i] = xe[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && in_valid) begin
      sh4   <= sh_n;
      last4 <= in_last;
    end
  end

  // ---------------- Stage 5: DC offset, clamp to max then min
  logic signed [ZW-1:0] dc_e, hi_e, lo_e;
  logic                 hi_below_lo;

  assign dc_e        = ZW'(cfg.dc);
  assign hi_e        = ZW'(cfg.max_val);
  assign lo_e        = ZW'(cfg.min_val);
  assign hi_below_lo = cfg.max_val < cfg.min_val;

  logic signed [ZW-1:0]              z     [icf_pkg::LANES];
  logic [icf_pkg::LANES-1:0]         gt, lt;
  logic [icf_pkg::LANES-1:0][icf_pkg::OUT_W-1:0] clamp_n;

  for (genvar i = 0; i < icf_pkg::LANES; i++) begin : g_clamp
    assign z[i]  = ZW'(sh4[i]) + dc_e;
    assign gt[i] = z[i] > hi_e;
    assign lt[i] = gt[i] ? hi_below_lo : (z[i] < lo_e);
    always_comb begin
      if (lt[i]) begin
        clamp_n[i] = cfg.min_val;
      end else if (gt[i]) begin
        clamp_n[i] = cfg.max_val;
      end else begin
        clamp_n[i] = z[i][icf_pkg::OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && v4) begin
      out_data <= clamp_n;
      out_last <= last4;
    end
  end

endmodule

// ===== hw/rtl/inverse_color_transform_finalize_unit.sv =====
// Inverse color transform with finalize: Y/Cb/Cr pixel in, clamped R/G/B pixel out.
// Throughput one pixel per cycle sustained while m_tready is high; five stages:
// products, sums, truncate/select, shift, offset/clamp. Each stage has its own valid
// and ready, so bubbles close up.
// Reset (synchronous, active high) empties the pipeline and restores register defaults.
// Depends on icf_pkg, icf_regs, icf_xform, icf_final.
module inverse_color_transform_finalize_unit #(
  parameter int FRAC_BITS   = icf_pkg::FRAC_BITS_DEF,
  parameter int COEF_BITS   = icf_pkg::COEF_BITS_DEF,
  parameter int SAMPLE_BITS = icf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  // pixel input
  input  logic                                        s_tvalid,
  output logic                                        s_tready,
  // y_sample, cb_sample, cr_sample (low to high), zero pad to bytes
  input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]          s_tdata,
  input  logic                                        s_tlast,   // last_in_row
  // pixel output
  output logic                                        m_tvalid,
  input  logic                                        m_tready,
  // red, green, blue (low to high), zero pad to bytes
  output logic [((3*icf_pkg::OUT_W+7)/8)*8-1:0]       m_tdata,
  output logic                                        m_tlast,   // row_done
  // configuration writes
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [icf_pkg::CFG_IDX_W-1:0]               cfg_index,
  input  logic [icf_pkg::CFG_DATA_W-1:0]              cfg_data
);

  localparam int XW     = SAMPLE_BITS + 4;
  localparam int DW_OUT = ((3*icf_pkg::OUT_W+7)/8)*8;

  icf_pkg::cfg_t cfg;

  icf_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Unpack the input transaction
  logic signed [SAMPLE_BITS-1:0] y_sample, cb_sample, cr_sample;

  assign y_sample  = $signed(s_tdata[SAMPLE_BITS-1:0]);
  assign cb_sample = $signed(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
  assign cr_sample = $signed(s_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]);

  logic                                xf_valid, xf_ready, xf_last;
  logic [icf_pkg::LANES-1:0][XW-1:0]   xf_x;

  icf_xform #(
    .FRAC_BITS   (FRAC_BITS),
    .COEF_BITS   (COEF_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_xform (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .y_in      (y_sample),
    .cb_in     (cb_sample),
    .cr_in     (cr_sample),
    .in_last   (s_tlast),
    .out_valid (xf_valid),
    .out_ready (xf_ready),
    .out_x     (xf_x),
    .out_last  (xf_last)
  );

  logic [icf_pkg::LANES-1:0][icf_pkg::OUT_W-1:0] rgb;

  icf_final #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_final (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (xf_valid),
    .in_ready  (xf_ready),
    .in_x      (xf_x),
    .in_last   (xf_last),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (rgb),
    .out_last  (m_tlast)
  );

  // Lane 0 red sits in the low bits
  assign m_tdata = DW_OUT'(rgb);

endmodule

// ===== hw/rtl/icf_chk.sv =====
// Port-level checker for the inverse color transform finalize unit, bound to the top level.
// Depends on icf_pkg and inverse_color_transform_finalize_unit_assert.svh.
`include "inverse_color_transform_finalize_unit_assert.svh"

module icf_chk (
  input logic                                        clk,
  input logic                                        rst,
  input logic                                        s_tready,
  input logic                                        m_tvalid,
  input logic                                        m_tready,
  input logic [((3*icf_pkg::OUT_W+7)/8)*8-1:0]       m_tdata,
  input logic                                        m_tlast
);

  localparam int DW_OUT = ((3*icf_pkg::OUT_W+7)/8)*8;
  localparam int PAD_LO = 3*icf_pkg::OUT_W;

  // Stalled output transaction holds
  `ICF_ASSERT_HOLD(a_out_hold, m_tvalid, m_tready, m_tdata)

  // Row marker holds with its pixel
  `ICF_ASSERT_HOLD(a_last_hold, m_tvalid, m_tready, m_tlast)

  // Pad bits above blue are zero
  `ICF_ASSERT_IMPLY(a_out_pad_zero, m_tvalid, m_tdata[DW_OUT-1:PAD_LO] == '0)

  // An empty output register means the whole pipeline can take a pixel
  `ICF_ASSERT_IMPLY(a_ready_when_empty, !m_tvalid, s_tready)

  // Reset flushes the pipeline
  `ICF_ASSERT_IMPLY(a_reset_flush, $past(rst), !m_tvalid)

endmodule

bind inverse_color_transform_finalize_unit icf_chk u_icf_chk (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tlast   (m_tlast)
);
